[design/rlbp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbp_pkg
// Shared constants and types of the run-length bit packer.
// ----------------------------------------------------------------------------
package rlbp_pkg;

	localparam int BYTE_W      = 8;
	// two closed runs of three codes each, at most, per item
	localparam int MAX_CODES   = 6;
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic batch_end;
		logic stream_end;
	} byte_flags_t;

endpackage

[design/rlbp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbp_queue
// Small register queue between the run tracker and the bit packer.
// ----------------------------------------------------------------------------
module rlbp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[design/rlbp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbp_front
// Run tracker: accepts symbols, closes runs and queues their packed codes.
// ----------------------------------------------------------------------------
module rlbp_front
	import rlbp_pkg::*;
#(
	parameter int SYMBOL_BITS = 7
) (
	clk, arst_n, s_tvalid, s_tready, s_tdata, s_tlast, q_full, q_push, q_data
);

	localparam int SB     = SYMBOL_BITS;
	localparam int IN_W   = ((SB + BYTE_W - 1) / BYTE_W) * BYTE_W;
	localparam int CODE_W = MAX_CODES * SB;
	localparam int NB_W   = $clog2(CODE_W + 1);
	localparam int E_W    = CODE_W + NB_W + 1;

	input  logic            clk;
	input  logic            arst_n;
	input  logic            s_tvalid;
	output logic            s_tready;
	input  logic [IN_W-1:0] s_tdata;   // [SB-1:0] symbol
	input  logic            s_tlast;   // end_of_stream
	input  logic            q_full;
	output logic            q_push;
	output logic [E_W-1:0]  q_data;    // {eos, nbits, code bits}

	localparam logic [SB-1:0] ESC = {SB{1'b1}};

	typedef enum logic [1:0] {
		RK_NONE,
		RK_SINGLE,
		RK_TRIPLE
	} run_kind_t;

	logic [SB-1:0] run_symbol_q;
	logic [SB-1:0] run_length_q;
	logic          run_open_q;

	logic          accept;
	logic [SB-1:0] sym;
	logic          extend;
	logic [SB-1:0] new_symbol;
	logic [SB-1:0] new_length;
	run_kind_t     k1;
	run_kind_t     k2;
	logic [3*SB-1:0] c1;
	logic [3*SB-1:0] c2;
	logic [CODE_W-1:0] bits;
	logic [NB_W-1:0]   nbits;

	function automatic run_kind_t kind_of(input logic open, input logic [SB-1:0] s,
			input logic [SB-1:0] l);
		run_kind_t k;
		if (!open) begin
			k = RK_NONE;
		end else if (l == SB'(1) && s != ESC) begin
			k = RK_SINGLE;
		end else begin
			k = RK_TRIPLE;
		end
		return k;
	endfunction

	function automatic logic [NB_W-1:0] kind_bits(input run_kind_t k);
		logic [NB_W-1:0] n;
		unique case (k)
			RK_SINGLE: n = NB_W'(SB);
			RK_TRIPLE: n = NB_W'(3 * SB);
			default:   n = '0;
		endcase
		return n;
	endfunction

	assign s_tready = !q_full;
	assign accept   = s_tvalid && !q_full;
	assign sym      = s_tdata[SB-1:0];

	always_comb begin
		extend = run_open_q && (sym == run_symbol_q) && (run_length_q != ESC);
		k1     = extend ? RK_NONE : kind_of(run_open_q, run_symbol_q, run_length_q);
		c1     = (k1 == RK_SINGLE) ? (3*SB)'(run_symbol_q) : {run_length_q, run_symbol_q, ESC};

		new_symbol = extend ? run_symbol_q : sym;
		new_length = extend ? run_length_q + 1'b1 : SB'(1);
		k2         = s_tlast ? kind_of(1'b1, new_symbol, new_length) : RK_NONE;
		c2         = (k2 == RK_SINGLE) ? (3*SB)'(new_symbol) : {new_length, new_symbol, ESC};
		if (k2 == RK_NONE) begin
			c2 = '0;
		end

		// second run's codes sit right after the first run's
		unique case (k1)
			RK_SINGLE: bits = CODE_W'({c2, c1[SB-1:0]});
			RK_TRIPLE: bits = {c2, c1};
			default:   bits = CODE_W'(c2);
		endcase
		nbits = kind_bits(k1) + kind_bits(k2);
	end

	assign q_push = accept && (nbits != '0);
	assign q_data = {s_tlast, nbits, bits};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_symbol_q <= '0;
			run_length_q <= '0;
			run_open_q   <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				run_symbol_q <= '0;
				run_length_q <= '0;
				run_open_q   <= 1'b0;
			end else begin
				run_symbol_q <= new_symbol;
				run_length_q <= new_length;
				run_open_q   <= 1'b1;
			end
		end
	end

endmodule

[design/rlbp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbp_back
// Bit packer: merges queued codes into the bit store and sends whole bytes.
// ----------------------------------------------------------------------------
module rlbp_back
	import rlbp_pkg::*;
#(
	parameter int SYMBOL_BITS = 7
) (
	clk, arst_n, q_empty, q_data, q_pop, m_tvalid, m_tready, m_tdata, m_flags
);

	localparam int SB      = SYMBOL_BITS;
	localparam int CODE_W  = MAX_CODES * SB;
	localparam int NB_W    = $clog2(CODE_W + 1);
	localparam int E_W     = CODE_W + NB_W + 1;
	localparam int STORE_W = ((CODE_W + 2 * BYTE_W - 2) / BYTE_W) * BYTE_W;
	localparam int FILL_W  = $clog2(STORE_W + 1);

	input  logic              clk;
	input  logic              arst_n;
	input  logic              q_empty;
	input  logic [E_W-1:0]    q_data;
	output logic              q_pop;
	output logic              m_tvalid;
	input  logic              m_tready;
	output logic [BYTE_W-1:0] m_tdata;
	output byte_flags_t       m_flags;

	localparam logic [FILL_W-1:0] ONE_BYTE  = FILL_W'(BYTE_W);
	localparam logic [FILL_W-1:0] TWO_BYTES = FILL_W'(2 * BYTE_W);

	logic [STORE_W-1:0] store_q;
	logic [FILL_W-1:0]  fill_q;
	logic               pend_q;
	logic               eos_q;
	logic               m_tvalid_q;
	logic [BYTE_W-1:0]  m_tdata_q;
	byte_flags_t        m_flags_q;

	logic               e_eos;
	logic [NB_W-1:0]    e_nbits;
	logic [CODE_W-1:0]  e_bits;
	logic               emit;
	logic               last_byte;
	logic [FILL_W-1:0]  f1;
	logic [STORE_W-1:0] st1;
	logic               merge;
	logic [FILL_W-1:0]  f2;
	logic [FILL_W-1:0]  f2_pad;

	assign {e_eos, e_nbits, e_bits} = q_data;

	always_comb begin
		emit      = (fill_q >= ONE_BYTE) && (!m_tvalid_q || m_tready);
		last_byte = pend_q && (fill_q < TWO_BYTES);
		f1        = emit ? fill_q - ONE_BYTE : fill_q;
		st1       = emit ? (store_q >> BYTE_W) : store_q;
		merge     = !q_empty && (f1 < ONE_BYTE);
		f2        = f1 + FILL_W'(e_nbits);
		// end of stream pads the leftover bits out to a whole byte
		if (f2[2:0] != 3'b000) begin
			f2_pad = {f2[FILL_W-1:3] + 1'b1, 3'b000};
		end else begin
			f2_pad = f2;
		end
	end

	assign q_pop    = merge;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_flags  = m_flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q    <= '0;
			fill_q     <= '0;
			pend_q     <= 1'b0;
			eos_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_flags_q  <= '0;
		end else begin
			if (merge) begin
				store_q <= st1 | (STORE_W'(e_bits) << f1[2:0]);
				fill_q  <= e_eos ? f2_pad : f2;
				pend_q  <= e_eos || (f2 >= ONE_BYTE);
				eos_q   <= e_eos;
			end else begin
				store_q <= st1;
				fill_q  <= f1;
				if (emit && last_byte) begin
					pend_q <= 1'b0;
				end
			end

			if (emit) begin
				m_tvalid_q           <= 1'b1;
				m_tdata_q            <= store_q[BYTE_W-1:0];
				m_flags_q.batch_end  <= last_byte;
				m_flags_q.stream_end <= last_byte && eos_q;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

[design/run_length_bit_packer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_bit_packer_unit
// Escape run-length encoder with LSB-first packing of codes into bytes.
// ----------------------------------------------------------------------------
// Input stream (s_*): one symbol per item in s_tdata, s_tlast marks the last
// symbol of a stream. Output stream (m_*): one packed byte per item, m_tuser
// flags the last byte caused by an input item, m_tlast the final byte of the
// compressed stream.
// Runs of one symbol go out as a single code; longer runs, and any run of the
// all-ones symbol, as escape, symbol, length. Runs are capped at the escape
// value. Leftover bits are zero padded at the end of a stream.
// Throughput: one symbol per cycle while s_tready is high; one byte per cycle
// out while m_tready is high. The byte sender takes one queued code group per
// cycle while fewer than eight bits are held, so it takes no new group until
// its whole bytes are out. Codes go via queue, bit store and output register.
// A four-entry queue parts run tracking from byte packing; s_tready drops only
// when it is full, which happens when m_tready stays low or runs end densely.
// Reset clears the open run, the bit store, the queue and the output register.
// ----------------------------------------------------------------------------
module run_length_bit_packer_unit
	import rlbp_pkg::*;
#(
	parameter int SYMBOL_BITS = 7
) (
	clk, arst_n, s_tvalid, s_tready, s_tdata, s_tlast, m_tvalid, m_tready, m_tdata,
	m_tuser, m_tlast
);

	localparam int IN_W   = ((SYMBOL_BITS + BYTE_W - 1) / BYTE_W) * BYTE_W;
	localparam int CODE_W = MAX_CODES * SYMBOL_BITS;
	localparam int NB_W   = $clog2(CODE_W + 1);
	localparam int E_W    = CODE_W + NB_W + 1;

	input  logic              clk;
	input  logic              arst_n;
	input  logic              s_tvalid;
	output logic              s_tready;
	input  logic [IN_W-1:0]   s_tdata;   // [SYMBOL_BITS-1:0] symbol, rest zero
	input  logic              s_tlast;   // end_of_stream
	output logic              m_tvalid;
	input  logic              m_tready;
	output logic [BYTE_W-1:0] m_tdata;   // [7:0] out_byte
	output logic              m_tuser;   // [0] batch_end
	output logic              m_tlast;   // stream_end

	logic           q_full;
	logic           q_push;
	logic [E_W-1:0] q_wdata;
	logic           q_empty;
	logic           q_pop;
	logic [E_W-1:0] q_rdata;
	byte_flags_t    flags;

	rlbp_front #(
		.SYMBOL_BITS(SYMBOL_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	rlbp_queue #(
		.WIDTH (E_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	rlbp_back #(
		.SYMBOL_BITS(SYMBOL_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_flags  (flags)
	);

	assign m_tuser = flags.batch_end;
	assign m_tlast = flags.stream_end;

endmodule
